// ----- rtl/kobms_pkg.sv -----
package kobms_pkg;

    localparam int KOBMS_MAX_POINTS = 256;
    localparam int KOBMS_MAX_K      = 7;

    // Hard limit on removed edges; subset and signature codes are sized for it.
    localparam int SLOT_LIMIT = 7;
    localparam int FRAG_SLOTS = SLOT_LIMIT - 1;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 18;
    localparam int SUM_W   = 21;
    localparam int LABEL_W = 4;
    localparam int ORD_W   = 3;
    localparam int K_W     = 3;

    typedef logic [ORD_W-1:0]   frag_idx_t;
    typedef logic [LABEL_W-1:0] label_t;

endpackage

// ----- rtl/kobms_dist.sv -----
module kobms_dist
    import kobms_pkg::*;
#(
    parameter int MAX_POINTS = KOBMS_MAX_POINTS,
    localparam int ADDR_W = $clog2(MAX_POINTS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COORD_W-1:0] wr_x,
    input  logic [COORD_W-1:0] wr_y,
    input  logic               start,
    input  logic [ADDR_W-1:0]  node_a,
    input  logic [ADDR_W-1:0]  node_b,
    output logic               done,
    output logic [DIST_W-1:0]  dist_val
);

    localparam int RAD_W   = 36;
    localparam int ROOT_IT = RAD_W / 2;
    localparam int IT_W    = $clog2(ROOT_IT + 1);

    typedef enum logic [2:0] {D_IDLE, D_DIFF, D_SQX, D_SQY, D_ROOT, D_OUT} dstate_t;

    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    dstate_t              state_reg;
    logic [COORD_W-1:0]   dx_reg, dy_reg;
    logic [2*COORD_W-1:0] sq_reg;
    logic [RAD_W-1:0]     rem_reg, root_reg, bit_reg;
    logic [IT_W-1:0]      it_reg;
    logic                 done_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [RAD_W-1:0]     trial;
    logic [2*COORD_W:0]   d2;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        ax_reg <= mem_x[node_a];
        ay_reg <= mem_y[node_a];
        bx_reg <= mem_x[node_b];
        by_reg <= mem_y[node_b];
    end

    assign trial = root_reg + bit_reg;
    assign d2    = (2*COORD_W+1)'(sq_reg) + (2*COORD_W+1)'(dy_reg * dy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            dist_reg  <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            sq_reg    <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
            it_reg    <= '0;
        end
        else
        begin
            done_reg <= (state_reg == D_OUT);
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                        state_reg <= D_DIFF;
                end
                D_DIFF:
                begin
                    dx_reg    <= (ax_reg >= bx_reg) ? ax_reg - bx_reg : bx_reg - ax_reg;
                    dy_reg    <= (ay_reg >= by_reg) ? ay_reg - by_reg : by_reg - ay_reg;
                    state_reg <= D_SQX;
                end
                D_SQX:
                begin
                    sq_reg    <= dx_reg * dx_reg;
                    state_reg <= D_SQY;
                end
                D_SQY:
                begin
                    // The root is taken of four times the squared distance.
                    rem_reg   <= RAD_W'({d2, 2'b00});
                    root_reg  <= '0;
                    bit_reg   <= RAD_W'(1) << (RAD_W - 2);
                    it_reg    <= IT_W'(ROOT_IT);
                    state_reg <= D_ROOT;
                end
                D_ROOT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    it_reg  <= it_reg - IT_W'(1);
                    if (it_reg == IT_W'(1))
                        state_reg <= D_OUT;
                end
                D_OUT:
                begin
                    dist_reg  <= DIST_W'((root_reg + RAD_W'(1)) >> 1);
                    state_reg <= D_IDLE;
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    assign done     = done_reg;
    assign dist_val = dist_reg;

endmodule

// ----- rtl/k_opt_best_move_search_core.sv -----
// k-opt best move search over a closed tour.
// Points enter on the s_ channel in tour order, one word per cycle while
// s_tready is high, into an on-chip coordinate memory; s_tlast marks the
// final point of the tour. Points beyond MAX_POINTS are dropped. After the
// final point the block drops s_tready and searches every k-edge subset
// and every irreducible reconnection. One shared distance unit (memory
// read, squares, 18-step bit-serial square root) serves the search. The
// single result word then goes to an output register on the m_ channel;
// loading of the next tour starts at once while that word waits. A new
// result waits in the done state while m_tvalid is high and m_tready is
// low. k_size is written through cfg_wr_en / cfg_wr_data while the block
// is idle; the user must keep to this, as the block does not enforce it.
// Reset clears the control state, sets k_size to 3 and empties the point
// count.
module k_opt_best_move_search_core
    import kobms_pkg::*;
#(
    parameter int MAX_POINTS = KOBMS_MAX_POINTS,
    parameter int MAX_K      = KOBMS_MAX_K
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,    // point_x[15:0], point_y[31:16]
    input  logic         s_tlast,    // last_point
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,    // best_gain[19:0], move_found[20],
                                     // signature_code[44:21], subset_code[100:45]
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int KMAX   = (MAX_K < SLOT_LIMIT) ? MAX_K : SLOT_LIMIT;

    typedef enum logic [3:0] {
        S_LOAD, S_REM_ISSUE, S_REM_WAIT, S_ADV, S_CHK,
        S_ADD_ISSUE, S_ADD_WAIT, S_CMP, S_SUB, S_DONE
    } state_t;

    state_t           state_reg;
    logic [K_W-1:0]   k_cfg_reg, k_reg;
    logic [CNT_W-1:0] cnt_reg, n_reg;
    logic [CNT_W-1:0] v_reg   [SLOT_LIMIT];
    frag_idx_t        ord_reg [SLOT_LIMIT];
    logic             rev_reg [SLOT_LIMIT];
    logic [2:0]       idx_reg;
    logic [SUM_W-1:0] rsum_reg, asum_reg, best_reg;
    logic [23:0]      bsig_reg;
    logic [55:0]      bsub_reg;
    logic             m_valid_reg;
    logic [103:0]     m_data_reg;

    logic             s_acc, store_ok, dist_start, dist_done;
    logic [CNT_W-1:0] cnt_new;
    logic [K_W-1:0]   k_eff;
    logic [DIST_W-1:0] dist_val;
    logic [CNT_W-1:0] raw_a, raw_b;
    logic [ADDR_W-1:0] node_a, node_b;

    frag_idx_t        ord_next [SLOT_LIMIT];
    logic             rev_next [SLOT_LIMIT];
    logic             adv_ok;
    logic [CNT_W-1:0] v_next [SLOT_LIMIT];
    logic             sub_ok;
    label_t           end_x [SLOT_LIMIT];
    label_t           end_y [SLOT_LIMIT];
    logic             reducible;
    logic [23:0]      sig_code;
    logic [55:0]      sub_code;
    logic [SUM_W-1:0] gain;

    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign store_ok = (cnt_reg < CNT_W'(MAX_POINTS));
    assign cnt_new  = store_ok ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign k_eff    = (k_cfg_reg < K_W'(2)) ? K_W'(2) :
                      (k_cfg_reg > K_W'(KMAX)) ? K_W'(KMAX) : k_cfg_reg;

    // Next reconnection: orientation counter with next-permutation carry.
    always_comb
    begin
        int        m, piv, lowj;
        logic      found;
        frag_idx_t ord_sw [SLOT_LIMIT];
        m     = int'(k_reg) - 1;
        piv   = -1;
        lowj  = 0;
        found = 1'b0;
        ord_sw   = ord_reg;
        rev_next = rev_reg;
        for (int ii = FRAG_SLOTS - 1; ii >= 0; ii--)
        begin
            if (ii < m && !found)
            begin
                rev_next[ii] = ~rev_reg[ii];
                if (!rev_reg[ii])
                begin
                    found = 1'b1;
                    piv   = ii;
                end
                else if (ii < m - 1 && ord_reg[ii] < ord_reg[ii+1])
                begin
                    found = 1'b1;
                    piv   = ii;
                    lowj  = ii + 1;
                    for (int jj = 0; jj < SLOT_LIMIT; jj++)
                        if (jj > ii && jj < m && ord_reg[jj] > ord_reg[ii])
                            lowj = jj;
                    ord_sw[ii]   = ord_reg[lowj];
                    ord_sw[lowj] = ord_reg[ii];
                end
            end
        end
        ord_next = ord_sw;
        for (int jj = 0; jj < SLOT_LIMIT; jj++)
            if (jj > piv && jj < m)
                ord_next[jj] = ord_sw[piv + m - jj];
        adv_ok = found;
    end

    // Next subset in colex order; the slot above the top one holds n.
    always_comb
    begin
        logic             stop;
        logic [CNT_W-1:0] v_up [SLOT_LIMIT];
        logic [CNT_W-1:0] v_inc;
        stop = 1'b0;
        for (int i = 0; i < SLOT_LIMIT; i++)
            v_up[i] = n_reg;
        for (int i = 0; i < SLOT_LIMIT - 1; i++)
            if (i + 1 < int'(k_reg))
                v_up[i] = v_reg[i+1];
        v_next = v_reg;
        for (int i = 0; i < SLOT_LIMIT; i++)
        begin
            v_inc = v_reg[i] + CNT_W'(1);
            if (i < int'(k_reg) && !stop)
            begin
                if (v_inc == v_up[i])
                    v_next[i] = CNT_W'(i);
                else
                begin
                    v_next[i] = v_inc;
                    stop      = 1'b1;
                end
            end
        end
        sub_ok = stop;
    end

    // Endpoint labels of the added edges and the reducibility test.
    always_comb
    begin
        label_t front_lab [SLOT_LIMIT];
        label_t back_lab  [SLOT_LIMIT];
        label_t last_lab;
        last_lab = LABEL_W'({k_reg, 1'b0}) - LABEL_W'(1);
        for (int i = 0; i < SLOT_LIMIT; i++)
        begin
            front_lab[i] = LABEL_W'({ord_reg[i], 1'b0}) + LABEL_W'(1)
                           + LABEL_W'(rev_reg[i]);
            back_lab[i]  = LABEL_W'({ord_reg[i], 1'b0}) + LABEL_W'(2)
                           - LABEL_W'(rev_reg[i]);
        end
        end_x[0] = '0;
        for (int i = 1; i < SLOT_LIMIT; i++)
            end_x[i] = back_lab[i-1];
        for (int i = 0; i < SLOT_LIMIT; i++)
            end_y[i] = (i == int'(k_reg) - 1) ? last_lab : front_lab[i];
        reducible = 1'b0;
        for (int i = 0; i < SLOT_LIMIT; i++)
            if (i < int'(k_reg))
                if (end_x[i] + LABEL_W'(1) == end_y[i] || end_y[i] + LABEL_W'(1) == end_x[i])
                    reducible = 1'b1;
    end

    always_comb
    begin
        label_t lx, ly;
        lx = end_x[idx_reg];
        ly = end_y[idx_reg];
        if (state_reg == S_ADD_ISSUE)
        begin
            raw_a = v_reg[lx[3:1]] + CNT_W'(lx[0]);
            raw_b = v_reg[ly[3:1]] + CNT_W'(ly[0]);
        end
        else
        begin
            raw_a = v_reg[idx_reg];
            raw_b = v_reg[idx_reg] + CNT_W'(1);
        end
    end

    // Node n is node 0 again.
    assign node_a = (raw_a >= n_reg) ? ADDR_W'(raw_a - n_reg) : ADDR_W'(raw_a);
    assign node_b = (raw_b >= n_reg) ? ADDR_W'(raw_b - n_reg) : ADDR_W'(raw_b);
    assign dist_start = (state_reg == S_REM_ISSUE) || (state_reg == S_ADD_ISSUE);

    always_comb
    begin
        sig_code = '0;
        sub_code = '0;
        for (int i = 0; i < FRAG_SLOTS; i++)
            if (i < int'(k_reg) - 1)
                sig_code[4*i +: 4] = {rev_reg[i], ord_reg[i]};
        for (int i = 0; i < SLOT_LIMIT; i++)
            if (i < int'(k_reg))
                sub_code[8*i +: 8] = 8'(v_reg[i]);
    end

    assign gain = rsum_reg - asum_reg;

    kobms_dist #(.MAX_POINTS(MAX_POINTS)) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s_acc && store_ok),
        .wr_addr  (ADDR_W'(cnt_reg)),
        .wr_x     (s_tdata[15:0]),
        .wr_y     (s_tdata[31:16]),
        .start    (dist_start),
        .node_a   (node_a),
        .node_b   (node_b),
        .done     (dist_done),
        .dist_val (dist_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            k_cfg_reg   <= K_W'(3);
            k_reg       <= K_W'(3);
            cnt_reg     <= '0;
            n_reg       <= '0;
            idx_reg     <= '0;
            rsum_reg    <= '0;
            asum_reg    <= '0;
            best_reg    <= '0;
            bsig_reg    <= '0;
            bsub_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            for (int i = 0; i < SLOT_LIMIT; i++)
            begin
                v_reg[i]   <= CNT_W'(i);
                ord_reg[i] <= ORD_W'(i);
                rev_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                k_cfg_reg <= cfg_wr_data;
            if (state_reg == S_DONE && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (s_tlast)
                        begin
                            cnt_reg  <= '0;
                            n_reg    <= cnt_new;
                            k_reg    <= k_eff;
                            idx_reg  <= '0;
                            rsum_reg <= '0;
                            best_reg <= '0;
                            bsig_reg <= '0;
                            bsub_reg <= '0;
                            for (int i = 0; i < SLOT_LIMIT; i++)
                            begin
                                v_reg[i]   <= CNT_W'(i);
                                ord_reg[i] <= ORD_W'(i);
                                rev_reg[i] <= 1'b0;
                            end
                            if (cnt_new < CNT_W'(k_eff))
                                state_reg <= S_DONE;
                            else
                                state_reg <= S_REM_ISSUE;
                        end
                        else
                            cnt_reg <= cnt_new;
                    end
                end
                S_REM_ISSUE:
                    state_reg <= S_REM_WAIT;
                S_REM_WAIT:
                begin
                    if (dist_done)
                    begin
                        rsum_reg <= rsum_reg + SUM_W'(dist_val);
                        if (idx_reg == k_reg - K_W'(1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_ADV;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_REM_ISSUE;
                        end
                    end
                end
                S_ADV:
                begin
                    ord_reg   <= ord_next;
                    rev_reg   <= rev_next;
                    state_reg <= adv_ok ? S_CHK : S_SUB;
                end
                S_CHK:
                begin
                    idx_reg   <= '0;
                    asum_reg  <= '0;
                    state_reg <= reducible ? S_ADV : S_ADD_ISSUE;
                end
                S_ADD_ISSUE:
                    state_reg <= S_ADD_WAIT;
                S_ADD_WAIT:
                begin
                    if (dist_done)
                    begin
                        asum_reg <= asum_reg + SUM_W'(dist_val);
                        if (idx_reg == k_reg - K_W'(1))
                            state_reg <= S_CMP;
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_ADD_ISSUE;
                        end
                    end
                end
                S_CMP:
                begin
                    // Strictly greater keeps the first of equal best moves.
                    if (rsum_reg > asum_reg && gain > best_reg)
                    begin
                        best_reg <= gain;
                        bsig_reg <= sig_code;
                        bsub_reg <= sub_code;
                    end
                    state_reg <= S_ADV;
                end
                S_SUB:
                begin
                    v_reg   <= v_next;
                    idx_reg <= '0;
                    rsum_reg <= '0;
                    state_reg <= sub_ok ? S_REM_ISSUE : S_DONE;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_data_reg  <= {3'b000, bsub_reg, bsig_reg,
                                        (best_reg != '0), best_reg[19:0]};
                        state_reg   <= S_LOAD;
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == S_REM_WAIT || state_reg == S_ADD_WAIT))
        else $error("distance result arrived outside a wait state");

    a_found_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20] == (m_tdata[19:0] != 20'd0)))
        else $error("move_found disagrees with best_gain");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted right after the last point");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench
    import kobms_pkg::*;
;

    localparam int  CLK_HALF   = 6;
    localparam int  DRAIN_WAIT = 40;
    localparam int  HOLD_OFF   = 20000;
    localparam int  STALL_LIMIT = 16000000;
    localparam int  ITEM_GOAL  = 1750;
    localparam int  STORE_SIZE = KOBMS_MAX_POINTS;

    typedef struct packed {
        logic [19:0] gain;
        logic        found;
        logic [23:0] signature;
        logic [55:0] subset;
    } move_t;

    typedef struct {
        bit          wr_k;
        logic [2:0]  k_val;
        logic [15:0] x;
        logic [15:0] y;
        bit          last;
        bit          typed;
        move_t       res;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_data;

    k_opt_best_move_search_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow of the block: tour memory, move search state and k register.
    logic [15:0] tour_x [STORE_SIZE];
    logic [15:0] tour_y [STORE_SIZE];
    int          tour_len;
    logic [2:0]  k_shadow;
    int          edge_start [8];
    int          frag_ord [7];
    int          frag_rev [7];

    move_t       move_q [$];
    move_t       typed_move;
    bit          typed_pending;
    int          errors;
    int          items_sent;
    bit          hold_req;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int tour_dist(int a, int b, int n);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d2;
        if (a >= n) a = a - n;
        if (b >= n) b = b - n;
        a = a % STORE_SIZE;
        b = b % STORE_SIZE;
        dx = (tour_x[a] >= tour_x[b]) ? tour_x[a] - tour_x[b] : tour_x[b] - tour_x[a];
        dy = (tour_y[a] >= tour_y[b]) ? tour_y[a] - tour_y[b] : tour_y[b] - tour_y[a];
        d2 = dx * dx + dy * dy;
        return int'((isqrt64(4 * d2) + 1) / 2);
    endfunction

    function automatic int label_node(int lbl);
        return edge_start[(lbl >> 1) % 8] + (lbl & 1);
    endfunction

    // Added edge i joins the back of fragment i-1 to the front of fragment i.
    function automatic void added_ends(int i, int k, output int ea, output int eb);
        ea = (i == 0) ? 0 : 2 * frag_ord[i-1] + 2 - frag_rev[i-1];
        eb = (i == k - 1) ? 2 * k - 1 : 2 * frag_ord[i] + 1 + frag_rev[i];
    endfunction

    function automatic bit next_reconnect(int k);
        int m;
        int i;
        int lo;
        int hi;
        int t;
        int low;
        m = k - 1;
        for (i = m - 1; i >= 0; i--)
        begin
            frag_rev[i] = frag_rev[i] ^ 1;
            if (frag_rev[i] != 0) break;
            if (i < m - 1 && frag_ord[i] < frag_ord[i+1])
            begin
                low = m - 1;
                while (frag_ord[i] >= frag_ord[low]) low--;
                t = frag_ord[i];
                frag_ord[i] = frag_ord[low];
                frag_ord[low] = t;
                break;
            end
        end
        lo = i + 1;
        hi = m - 1;
        while (lo < hi)
        begin
            t = frag_ord[lo];
            frag_ord[lo] = frag_ord[hi];
            frag_ord[hi] = t;
            lo++;
            hi--;
        end
        return i >= 0;
    endfunction

    function automatic bit is_reducible(int k);
        int ea;
        int eb;
        for (int i = 0; i < k; i++)
        begin
            added_ends(i, k, ea, eb);
            if (ea + 1 == eb || eb + 1 == ea) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit next_subset(int k);
        int i;
        i = 0;
        while (i < k && edge_start[i] + 1 == edge_start[i+1])
        begin
            edge_start[i] = i;
            i++;
        end
        if (i < k)
        begin
            edge_start[i]++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic move_t best_move(int k, int n);
        int          removed;
        int          added;
        int          ea;
        int          eb;
        longint      gain;
        int          best;
        logic [23:0] sig;
        logic [55:0] sub;
        move_t       r;
        best = 0;
        sig = '0;
        sub = '0;
        for (int i = 0; i < 8; i++) edge_start[i] = i;
        for (int i = 0; i < 7; i++)
        begin
            frag_ord[i] = i;
            frag_rev[i] = 0;
        end
        if (n >= k)
        begin
            edge_start[k] = n;
            do
            begin
                removed = 0;
                for (int i = 0; i < k; i++)
                    removed += tour_dist(edge_start[i], edge_start[i] + 1, n);
                while (next_reconnect(k))
                begin
                    if (!is_reducible(k))
                    begin
                        added = 0;
                        for (int i = 0; i < k; i++)
                        begin
                            added_ends(i, k, ea, eb);
                            added += tour_dist(label_node(ea), label_node(eb), n);
                        end
                        gain = longint'(removed) - longint'(added);
                        if (gain > best)
                        begin
                            best = int'(gain);
                            sig = '0;
                            for (int i = 0; i + 1 < k; i++)
                            begin
                                sig[4*i +: 3] = frag_ord[i][2:0];
                                sig[4*i + 3]  = frag_rev[i][0];
                            end
                            sub = '0;
                            for (int i = 0; i < k; i++)
                                sub[8*i +: 8] = edge_start[i][7:0];
                        end
                    end
                end
            end
            while (next_subset(k));
        end
        r.gain      = best[19:0];
        r.found     = (best > 0);
        r.signature = sig;
        r.subset    = sub;
        return r;
    endfunction

    // Input side: track the k register and the tour, predict at the last point.
    always @(posedge clk or negedge rst_n)
    begin
        int k_eff;
        if (!rst_n)
        begin
            k_shadow <= 3'd3;
            tour_len = 0;
        end
        else
        begin
            if (cfg_wr_en) k_shadow <= cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                if (tour_len < STORE_SIZE)
                begin
                    tour_x[tour_len] = s_tdata[15:0];
                    tour_y[tour_len] = s_tdata[31:16];
                    tour_len++;
                end
                if (s_tlast)
                begin
                    k_eff = (k_shadow < 2) ? 2 : ((k_shadow > KOBMS_MAX_K) ? KOBMS_MAX_K : k_shadow);
                    if (typed_pending)
                        move_q.push_back(typed_move);
                    else
                        move_q.push_back(best_move(k_eff, tour_len));
                    tour_len = 0;
                end
            end
        end
    end

    // Output side: compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        move_t got;
        move_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[19:0], m_tdata[20], m_tdata[44:21], m_tdata[100:45]};
            if (move_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word %h", $realtime, got);
            end
            else
            begin
                want = move_q.pop_front();
                if (got.gain !== want.gain)
                begin
                    errors++;
                    $display("%0t: best_gain expected %0d actual %0d", $realtime, want.gain, got.gain);
                end
                if (got.found !== want.found)
                begin
                    errors++;
                    $display("%0t: move_found expected %0d actual %0d", $realtime, want.found, got.found);
                end
                if (got.signature !== want.signature)
                begin
                    errors++;
                    $display("%0t: signature_code expected %h actual %h", $realtime,
                             want.signature, got.signature);
                end
                if (got.subset !== want.subset)
                begin
                    errors++;
                    $display("%0t: subset_code expected %h actual %h", $realtime,
                             want.subset, got.subset);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("k_opt_best_move_search_core: mismatch");
            $finish;
        end
    end

    // Receiver: changes its stall pattern now and then; one long hold-off on request.
    initial
    begin
        int mode;
        int tick;
        m_tready <= 1'b0;
        mode = 0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= (tick % 4 != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    int burst_left;

    task automatic send_word(logic [15:0] x, logic [15:0] y, bit last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until the block has delivered everything, then writes k_size.
    task automatic write_k(logic [2:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (move_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coord(int style);
        case (style)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 15));
            default: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    localparam move_t NO_MOVE = '0;

    stim_row_t directed [] = '{
        '{0, 3'd0, 16'd0,     16'd0,     1, 1, NO_MOVE},
        '{1, 3'd2, 16'd0,     16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'hFFFF,  16'hFFFF,  0, 0, NO_MOVE},
        '{0, 3'd0, 16'hFFFF,  16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd0,     16'hFFFF,  1, 0, NO_MOVE},
        '{1, 3'd0, 16'd5,     16'd5,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd5,     16'd5,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd5,     16'd5,     1, 1, NO_MOVE},
        '{1, 3'd1, 16'd0,     16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd100,   16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd0,     16'd100,   0, 0, NO_MOVE},
        '{0, 3'd0, 16'd100,   16'd100,   1, 0, NO_MOVE},
        '{1, 3'd7, 16'd1,     16'd2,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd3,     16'd4,     1, 1, NO_MOVE},
        '{1, 3'd6, 16'hFFFF,  16'd0,     1, 1, NO_MOVE},
        '{1, 3'd5, 16'd0,     16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd9,     16'd9,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd0,     16'd9,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd9,     16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd4,     16'hFFFF,  1, 0, NO_MOVE},
        '{1, 3'd3, 16'd0,     16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd10,    16'd0,     0, 0, NO_MOVE},
        '{0, 3'd0, 16'd0,     16'd10,    0, 0, NO_MOVE},
        '{0, 3'd0, 16'd10,    16'd10,    0, 0, NO_MOVE},
        '{0, 3'd0, 16'd5,     16'd5,     1, 0, NO_MOVE}
    };

    initial
    begin
        int          k_now;
        int          k_eff;
        int          n;
        int          style;
        int          tours;
        int          max_len;
        logic [2:0]  k_pick;
        errors        = 0;
        items_sent    = 0;
        hold_req      = 1'b0;
        typed_pending <= 1'b0;
        typed_move    <= '0;
        idle_cycles   = 0;
        burst_left    = 1;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tlast       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The typed expectation changes after the edge that takes the word before it.
        foreach (directed[i])
        begin
            if (directed[i].wr_k) write_k(directed[i].k_val);
            typed_pending <= directed[i].last && directed[i].typed;
            typed_move    <= directed[i].res;
            send_word(directed[i].x, directed[i].y, directed[i].last);
        end
        typed_pending <= 1'b0;

        // Overfull tour: the extra points are dropped, even the one marked last.
        write_k(3'd2);
        for (int i = 0; i < STORE_SIZE + 2; i++)
            send_word(pick_coord(1), pick_coord(1), i == STORE_SIZE + 1);

        k_now = 2;
        tours = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 15))
                    0:       k_pick = 3'd0;
                    1:       k_pick = 3'd1;
                    2:       k_pick = 3'd4;
                    3:       k_pick = 3'd5;
                    4:       k_pick = 3'd6;
                    5:       k_pick = 3'd7;
                    6, 7, 8: k_pick = 3'd3;
                    default: k_pick = 3'd2;
                endcase
                write_k(k_pick);
                k_now = k_pick;
            end
            k_eff = (k_now < 2) ? 2 : k_now;
            case (k_eff)
                2:       max_len = 10;
                3:       max_len = 7;
                4:       max_len = 5;
                5:       max_len = 5;
                default: max_len = k_eff - 1;
            endcase
            // Several short tours offered while the receiver holds off fill the block.
            if (tours == 40)
            begin
                hold_req = 1'b1;
                for (int t = 0; t < 3; t++)
                    for (int i = 0; i < 3; i++)
                        send_word(pick_coord(0), pick_coord(0), i == 2);
            end
            n = $urandom_range(1, max_len);
            style = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                send_word(pick_coord(style), pick_coord($urandom_range(0, 2)), i == n - 1);
            tours++;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (move_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("k_opt_best_move_search_core: match");
        else
            $display("k_opt_best_move_search_core: mismatch");
        $finish;
    end

endmodule
